@@ rtl/core/kpt_pkg.sv @@
// ----------------------------------------------------------------------------
// kpt_pkg: shared types for the keyed policy table
// Request and result structs, record layout and operation codes.
// ----------------------------------------------------------------------------
package kpt_pkg;

    typedef enum logic [1:0]
    {
        OP_UPSERT  = 2'd0,
        OP_FIND    = 2'd1,
        OP_SET_DIS = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef struct packed
    {
        logic [1:0]  op;
        logic [63:0] chan_id;
        logic        dir;
        logic        disable_flag;
        logic [31:0] stamp;
        logic [15:0] cltv_delta;
        logic [63:0] min_amount;
        logic [63:0] max_amount;
        logic [31:0] base_fee;
        logic [31:0] ppm_fee;
    } req_t;

    typedef struct packed
    {
        logic        hit;
        logic        evicted;
        logic        found_disabled;
        logic [31:0] found_stamp;
        logic [15:0] found_cltv_delta;
        logic [63:0] found_min_amount;
        logic [63:0] found_max_amount;
        logic [31:0] found_base_fee;
        logic [31:0] found_ppm_fee;
        logic [6:0]  entries_used;
    } rsp_t;

    // one stored record
    typedef struct packed
    {
        logic [63:0] chan_id;
        logic        dir;
        logic        disabled;
        logic [31:0] stamp;
        logic [15:0] cltv;
        logic [63:0] min;
        logic [63:0] max;
        logic [31:0] base;
        logic [31:0] ppm;
    } rec_t;

    // per-cycle command broadcast from control to every cell
    typedef struct packed
    {
        logic write_hit;   // overwrite the matching cell
        logic set_dis;     // change disabled flag of the matching cell
        logic dis_val;
        logic shift;       // cells at or above evict position take the upper neighbor
        logic append;      // write the cell at the fill position
    } cell_cmd_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } state_t;

endpackage

@@ rtl/core/kpt_cell.sv @@
// ----------------------------------------------------------------------------
// kpt_cell: one table slot
// Holds a record, compares its key, and takes its upper neighbor on shift.
// ----------------------------------------------------------------------------
module kpt_cell
    import kpt_pkg::*;
(
    input  logic      clk,
    input  logic      live,        // position below the fill count
    input  logic      at_fill,     // position equal to the fill count
    input  logic      shift_here,  // position at or above the evicted one
    input  logic      is_hit,      // this cell is the first match
    input  cell_cmd_t cmd,
    input  rec_t      new_rec,
    input  rec_t      upper_rec,
    input  logic [63:0] key_id,
    input  logic      key_dir,
    output rec_t      rec,
    output logic      match
);

    rec_t rec_reg;

    assign rec   = rec_reg;
    assign match = live && (rec_reg.chan_id == key_id) && (rec_reg.dir == key_dir);

    // record update
    always_ff @(posedge clk)
    begin
        if (cmd.write_hit && is_hit)
        begin
            rec_reg <= new_rec;
        end
        else if (cmd.set_dis && is_hit)
        begin
            rec_reg.disabled <= cmd.dis_val;
        end
        else if (cmd.shift && shift_here)
        begin
            rec_reg <= upper_rec;
        end
        else if (cmd.append && at_fill)
        begin
            rec_reg <= new_rec;
        end
    end

endmodule

@@ rtl/core/keyed_policy_table_oldest_evict.sv @@
// Per request: search, then (when a full table evicts) a shift down the cell
// chain, then write, then result. A new request is accepted only in idle,
// after the result has been taken, so requests never overlap.
// Reset: asynchronous active low; clears fill count and control, records
// stay undefined until written.
// ----------------------------------------------------------------------------
// keyed_policy_table_oldest_evict: keyed record table with oldest eviction
// Chain of compare cells with a registered first-match and oldest search.
// ----------------------------------------------------------------------------
module keyed_policy_table_oldest_evict
    import kpt_pkg::*;
#(
    parameter int TABLE_SIZE = 64
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output rsp_t out_data
);

    localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CW = $clog2(TABLE_SIZE + 1);
    localparam int NP = 1 << IW;

    state_t          state_reg, state_next;
    req_t            req_reg;
    logic [CW-1:0]   count_reg, count_next;
    logic            evict_reg, evict_next;
    logic            hit_reg, hit_next;
    logic [IW-1:0]   hidx_reg, hidx_next;
    logic [IW-1:0]   oidx_reg, oidx_next;
    logic            phase_reg, phase_next;
    rsp_t            rsp_reg, rsp_next;
    cell_cmd_t       cmd;

    rec_t            recs [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] match;
    rec_t            new_rec;

    assign new_rec = '{chan_id: req_reg.chan_id, dir: req_reg.dir,
                       disabled: req_reg.disable_flag, stamp: req_reg.stamp,
                       cltv: req_reg.cltv_delta, min: req_reg.min_amount,
                       max: req_reg.max_amount, base: req_reg.base_fee,
                       ppm: req_reg.ppm_fee};

    // cell chain
    for (genvar g = 0; g < TABLE_SIZE; g++)
    begin : g_cell
        rec_t up;
        if (g == TABLE_SIZE - 1)
        begin : g_top
            assign up = recs[g];
        end
        else
        begin : g_mid
            assign up = recs[g+1];
        end
        kpt_cell u_cell
        (
            .clk        (clk),
            .live       (CW'(g) < count_reg),
            .at_fill    (CW'(g) == count_reg),
            .shift_here (IW'(g) >= oidx_reg),
            .is_hit     (hit_reg && (hidx_reg == IW'(g))),
            .cmd        (cmd),
            .new_rec    (new_rec),
            .upper_rec  (up),
            .key_id     (req_reg.chan_id),
            .key_dir    (req_reg.dir),
            .rec        (recs[g]),
            .match      (match[g])
        );
    end

    // first match (priority search over the cells)
    logic          m_any;
    logic [IW-1:0] m_idx;
    logic [IW-1:0] o_idx;
    always_comb
    begin
        m_any = 1'b0;
        m_idx = '0;
        for (int i = TABLE_SIZE - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                m_any = 1'b1;
                m_idx = IW'(i);
            end
        end
    end

    // oldest position: compare tree, left (lower) side wins on equal stamps
    logic [31:0]   t_stamp [2*NP];
    logic [IW-1:0] t_idx   [2*NP];
    always_comb
    begin
        t_stamp[0] = '0;
        t_idx[0]   = '0;
        for (int i = 0; i < NP; i++)
        begin
            t_stamp[NP+i] = '1;
            t_idx[NP+i]   = IW'(i);
        end
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            t_stamp[NP+i] = recs[i].stamp;
        end
        for (int n = NP - 1; n >= 1; n--)
        begin
            if (t_stamp[2*n+1] < t_stamp[2*n])
            begin
                t_stamp[n] = t_stamp[2*n+1];
                t_idx[n]   = t_idx[2*n+1];
            end
            else
            begin
                t_stamp[n] = t_stamp[2*n];
                t_idx[n]   = t_idx[2*n];
            end
        end
        o_idx = t_idx[1];
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_data  = rsp_reg;

    // control
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        evict_next = evict_reg;
        hit_next   = hit_reg;
        hidx_next  = hidx_reg;
        oidx_next  = oidx_reg;
        phase_next = phase_reg;
        rsp_next   = rsp_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                phase_next = 1'b0;
                hit_next   = 1'b0;
                evict_next = 1'b0;
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!phase_reg)
                begin
                    // search cycle
                    hit_next   = m_any;
                    hidx_next  = m_idx;
                    oidx_next  = o_idx;
                    evict_next = (req_reg.op == OP_UPSERT) && !m_any
                                 && (count_reg == CW'(TABLE_SIZE));
                    phase_next = 1'b1;
                end
                else if (evict_reg)
                begin
                    cmd.shift  = 1'b1;
                    count_next = count_reg - CW'(1);
                    evict_next = 1'b0;
                    rsp_next.evicted = 1'b1;
                end
                else
                begin
                    rsp_next = '0;
                    rsp_next.evicted = rsp_reg.evicted;
                    unique case (req_reg.op) inside
                        OP_UPSERT:
                        begin
                            cmd.write_hit = hit_reg;
                            cmd.append    = !hit_reg;
                            rsp_next.hit  = hit_reg;
                            rsp_next.found_disabled   = new_rec.disabled;
                            rsp_next.found_stamp      = new_rec.stamp;
                            rsp_next.found_cltv_delta = new_rec.cltv;
                            rsp_next.found_min_amount = new_rec.min;
                            rsp_next.found_max_amount = new_rec.max;
                            rsp_next.found_base_fee   = new_rec.base;
                            rsp_next.found_ppm_fee    = new_rec.ppm;
                            if (!hit_reg)
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_FIND, OP_SET_DIS:
                        begin
                            cmd.set_dis = hit_reg && (req_reg.op == OP_SET_DIS);
                            cmd.dis_val = req_reg.disable_flag;
                            if (hit_reg)
                            begin
                                rsp_next.hit = 1'b1;
                                rsp_next.found_disabled =
                                    (req_reg.op == OP_SET_DIS) ? req_reg.disable_flag
                                                               : recs[hidx_reg].disabled;
                                rsp_next.found_stamp      = recs[hidx_reg].stamp;
                                rsp_next.found_cltv_delta = recs[hidx_reg].cltv;
                                rsp_next.found_min_amount = recs[hidx_reg].min;
                                rsp_next.found_max_amount = recs[hidx_reg].max;
                                rsp_next.found_base_fee   = recs[hidx_reg].base;
                                rsp_next.found_ppm_fee    = recs[hidx_reg].ppm;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    rsp_next.entries_used = 7'(count_next);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (state_reg == ST_IDLE)
        begin
            rsp_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            evict_reg <= 1'b0;
            hit_reg   <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            evict_reg <= evict_next;
            hit_reg   <= hit_next;
            phase_reg <= phase_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hidx_reg <= hidx_next;
        oidx_reg <= oidx_next;
        rsp_reg  <= rsp_next;
        if (in_valid && in_ready)
        begin
            req_reg <= in_data;
        end
    end

endmodule

@@ rtl/core/kpt_checker.sv @@
// ----------------------------------------------------------------------------
// kpt_checker: port-level checks for the keyed policy table
// Watches handshakes and result fields on the top-level ports.
// ----------------------------------------------------------------------------
module kpt_checker
    import kpt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input rsp_t out_data
);

    // result held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // no new request while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request accepted while result pending");

    // eviction never reports a hit
    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.evicted |-> !out_data.hit)
        else $error("evicted with hit");

    // accepted request cannot produce a result next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result too early");

endmodule

bind keyed_policy_table_oldest_evict kpt_checker u_kpt_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
